// ===== hw/rtl/idl_pkg.sv =====
// Shared types and constants for the identity number check block.
`timescale 1ns / 1ps

package idl_pkg;

    // One character request into the block.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_req;

    // One result request out of the block.
    typedef struct packed {
        logic [2:0]  status;
        logic [24:0] date_key;
    } t_out_req;

    // Closing view of a number, passed from the scanner to the result stages.
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] yy;
        logic [6:0] mm;
        logic [6:0] dd;
    } t_scan_done;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LEN    = 3'd1;
    localparam logic [2:0] ST_BAD_DATE   = 3'd2;
    localparam logic [2:0] ST_NO_DASH    = 3'd3;
    localparam logic [2:0] ST_BAD_SERIAL = 3'd4;
    localparam logic [2:0] ST_BAD_CHECK  = 3'd5;

    // Character positions
    localparam logic [3:0] DASH_POS  = 4'd6;
    localparam logic [3:0] CHECK_POS = 4'd10;
    localparam logic [3:0] ID_LEN    = 4'd11;
    localparam logic [3:0] POS_SAT   = 4'd12;

    // Character codes
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Date key arithmetic
    localparam logic [6:0]  PIVOT_RESET = 7'd25;
    localparam logic [11:0] CENTURY_20  = 12'd2000;
    localparam logic [11:0] CENTURY_19  = 12'd1900;
    localparam logic [13:0] YEAR_SCALE  = 14'd10000;
    localparam logic [6:0]  MONTH_SCALE = 7'd100;

endpackage

// ===== hw/rtl/idl_char_scan.sv =====
// Per-character format and Luhn scanner holding the running number state.
`timescale 1ns / 1ps

module idl_char_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  idl_pkg::t_in_req   i_req,
    output idl_pkg::t_scan_done o_done
);
    import idl_pkg::*;

    logic [3:0] r_pos, n_pos;
    logic [3:0] r_luhn, n_luhn;
    logic [2:0] r_err, n_err;
    logic [6:0] r_yy, n_yy;
    logic [6:0] r_mm, n_mm;
    logic [6:0] r_dd, n_dd;

    logic       w_is_digit;
    logic [3:0] w_digit;
    logic       w_double;
    logic [4:0] w_prod;
    logic [4:0] w_sum;
    logic [3:0] w_luhn_add;
    logic [3:0] w_expect;
    logic [10:0] w_acc;
    logic [6:0] w_acc_src;
    logic [2:0] w_err_here;

    assign w_is_digit = (i_req.char_code >= CHAR_ZERO) && (i_req.char_code <= CHAR_NINE);
    assign w_digit    = w_is_digit ? 4'(i_req.char_code - CHAR_ZERO) : 4'd0;

    // Weight 2 on even weight index: positions 0..5 directly, 7..9 shifted by one.
    assign w_double   = (r_pos < DASH_POS) ? ~r_pos[0] : r_pos[0];

    always_comb begin
        w_prod = w_double ? {w_digit, 1'b0} : {1'b0, w_digit};
        if (w_prod >= 5'd10) begin
            w_prod = w_prod - 5'd9;
        end
        w_sum = {1'b0, r_luhn} + w_prod;
        if (w_sum >= 5'd10) begin
            w_sum = w_sum - 5'd10;
        end
        w_luhn_add = w_sum[3:0];
    end

    assign w_expect = (r_luhn == 4'd0) ? 4'd0 : 4'(4'd10 - r_luhn);

    // Pick which two-digit field this date digit feeds.
    always_comb begin
        if (r_pos < 4'd2) begin
            w_acc_src = r_yy;
        end else if (r_pos < 4'd4) begin
            w_acc_src = r_mm;
        end else begin
            w_acc_src = r_dd;
        end
        w_acc = (11'(w_acc_src) * 11'd10) + 11'(w_digit);
    end

    always_comb begin
        w_err_here = ST_OK;
        n_luhn     = r_luhn;
        n_yy       = r_yy;
        n_mm       = r_mm;
        n_dd       = r_dd;
        if (r_pos < DASH_POS) begin
            if (!w_is_digit) begin
                w_err_here = ST_BAD_DATE;
            end else begin
                n_luhn = w_luhn_add;
                if (r_pos < 4'd2) begin
                    n_yy = w_acc[6:0];
                end else if (r_pos < 4'd4) begin
                    n_mm = w_acc[6:0];
                end else begin
                    n_dd = w_acc[6:0];
                end
            end
        end else if (r_pos == DASH_POS) begin
            if (i_req.char_code != CHAR_DASH) begin
                w_err_here = ST_NO_DASH;
            end
        end else if (r_pos < CHECK_POS) begin
            if (!w_is_digit) begin
                w_err_here = ST_BAD_SERIAL;
            end else begin
                n_luhn = w_luhn_add;
            end
        end else if (r_pos == CHECK_POS) begin
            if (!w_is_digit) begin
                w_err_here = ST_BAD_SERIAL;
            end else if (w_digit != w_expect) begin
                w_err_here = ST_BAD_CHECK;
            end
        end
        n_err = (r_err == ST_OK) ? w_err_here : r_err;
        n_pos = (r_pos < POS_SAT) ? 4'(r_pos + 4'd1) : r_pos;
    end

    always_comb begin
        o_done.status = (n_pos != ID_LEN) ? ST_BAD_LEN : n_err;
        o_done.yy     = n_yy;
        o_done.mm     = n_mm;
        o_done.dd     = n_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 4'd0;
            r_luhn <= 4'd0;
            r_err  <= ST_OK;
            r_yy   <= 7'd0;
            r_mm   <= 7'd0;
            r_dd   <= 7'd0;
        end else if (i_take) begin
            if (i_req.last_char) begin
                r_pos  <= 4'd0;
                r_luhn <= 4'd0;
                r_err  <= ST_OK;
                r_yy   <= 7'd0;
                r_mm   <= 7'd0;
                r_dd   <= 7'd0;
            end else begin
                r_pos  <= n_pos;
                r_luhn <= n_luhn;
                r_err  <= n_err;
                r_yy   <= n_yy;
                r_mm   <= n_mm;
                r_dd   <= n_dd;
            end
        end
    end

endmodule

// ===== hw/rtl/id_number_luhn_validator_top.sv =====
// Top level of the identity number format and Luhn check block.
`timescale 1ns / 1ps
//
// Usage:
//   Feed an identity number of the form YYMMDD-XXXX one ASCII character per
//   request on the input channel (i_in_valid / o_in_ready / i_in_req), with
//   last_char set on the final character. Each number closed by last_char
//   yields one result request on the output channel (o_out_valid /
//   i_out_ready / o_out_req): a status code and, when the status is ok, the
//   date key yyyymmdd.
//   The century pivot is written through i_cfg_valid / o_cfg_ready /
//   i_cfg_data; the port is always ready. Write it only while idle.
// Throughput: one character per cycle while o_in_ready is high, set by the
//   character scanner. Path: the edge that accepts the last character
//   loads the date-key stage, and the output register, fed by the date-key
//   multiply-add, loads from that stage once it is free.
// Reset: synchronous, active low; clears the number state, both result
//   stages and sets the pivot to 25.
// Stall: when the receiver holds i_out_ready low the result holds in the
//   output register, the date-key stage fills, and o_in_ready drops only
//   once both are full; characters that do not close a number keep flowing
//   while space remains.

module id_number_luhn_validator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  idl_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output idl_pkg::t_out_req o_out_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);
    import idl_pkg::*;

    logic        w_take;
    logic        w_close;
    t_scan_done  w_done;

    logic [6:0]  r_pivot;

    // Date-key stage
    logic        r_s1_valid;
    logic [2:0]  r_s1_status;
    logic [11:0] r_s1_year;
    logic [6:0]  r_s1_month;
    logic [6:0]  r_s1_day;
    logic [11:0] n_s1_year;

    // Output register
    logic        r_out_valid;
    t_out_req    r_out_req;
    t_out_req    n_out_req;

    logic        w_out_free;
    logic        w_s1_free;
    logic [25:0] w_key_sum;

    assign o_cfg_ready = 1'b1;

    // Advance the output register when it is empty or being taken.
    assign w_out_free = !r_out_valid || i_out_ready;
    // Date-key stage can load when empty or when it moves on this cycle.
    assign w_s1_free  = !r_s1_valid || w_out_free;

    assign o_in_ready = w_s1_free;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_close    = w_take && i_in_req.last_char;

    idl_char_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_req  (i_in_req),
        .o_done (w_done)
    );

    // Pick the century from the pivot.
    assign n_s1_year = (w_done.yy <= r_pivot) ? (CENTURY_20 + 12'(w_done.yy))
                                              : (CENTURY_19 + 12'(w_done.yy));

    // Build the date key: year*10000 + month*100 + day, zero on any error.
    assign w_key_sum = (26'(r_s1_year) * 26'(YEAR_SCALE))
                     + (26'(r_s1_month) * 26'(MONTH_SCALE))
                     + 26'(r_s1_day);

    always_comb begin
        n_out_req.status   = r_s1_status;
        n_out_req.date_key = (r_s1_status == ST_OK) ? w_key_sum[24:0] : 25'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot <= PIVOT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pivot <= i_cfg_data;
        end
    end

    // Hold the closed number until the output register takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_s1_status <= w_done.status;
            r_s1_year   <= n_s1_year;
            r_s1_month  <= w_done.mm;
            r_s1_day    <= w_done.dd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // A closing character always lands in the date-key stage.
    a_close_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> r_s1_valid)
        else $error("closed number not captured");

    // An ok result always carries a date key, an error result never does.
    a_ok_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_req.status == ST_OK)) |-> (o_out_req.date_key != 25'd0))
        else $error("ok status with zero date key");

    a_err_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_req.status != ST_OK)) |-> (o_out_req.date_key == 25'd0))
        else $error("error status with date key");

    // A full pipeline that cannot drain must refuse new characters.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while pipeline blocked");

endmodule
